@@ rtl/core/general_purpose_timer_channel_core_assert.svh @@
// Assertion macros shared by the timer channel RTL.
// They expand to concurrent assertions in simulation and to nothing otherwise.
`ifndef GENERAL_PURPOSE_TIMER_CHANNEL_CORE_ASSERT_SVH
`define GENERAL_PURPOSE_TIMER_CHANNEL_CORE_ASSERT_SVH

`ifndef SYNTHESIS

// Same-cycle implication.
`define GPTC_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication.
`define GPTC_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`else

`define GPTC_ASSERT_NOW(label, clk, rst, ante, cons, msg)

`define GPTC_ASSERT_NEXT(label, clk, rst, ante, cons, msg)

`endif

`endif

@@ rtl/core/gptc_pkg.sv @@
`timescale 1ns / 1ps

package gptc_pkg;

   // Bus data width and default sizes of the counter and prescaler.
   localparam int DATA_W                = 32;
   localparam int COUNTER_WIDTH_DEFAULT  = 32;
   localparam int PRESCALE_WIDTH_DEFAULT = 16;

   // Request commands.
   localparam logic [1:0] CMD_TICK  = 2'd0;
   localparam logic [1:0] CMD_READ  = 2'd1;
   localparam logic [1:0] CMD_WRITE = 2'd2;

   // Register map.
   localparam logic [3:0] REG_CTRL      = 4'd0;
   localparam logic [3:0] REG_IRQ_EN    = 4'd1;
   localparam logic [3:0] REG_STATUS    = 4'd2;
   localparam logic [3:0] REG_EVENT     = 4'd3;
   localparam logic [3:0] REG_CHAN_MODE = 4'd4;
   localparam logic [3:0] REG_CHAN_EN   = 4'd5;
   localparam logic [3:0] REG_COUNT     = 4'd6;
   localparam logic [3:0] REG_PRESCALE  = 4'd7;
   localparam logic [3:0] REG_RELOAD    = 4'd8;
   localparam logic [3:0] REG_COMPARE   = 4'd9;

   // Output compare reference modes.
   localparam logic [2:0] OCM_FORCE_ACTIVE = 3'd5;
   localparam logic [2:0] OCM_PWM1         = 3'd6;
   localparam logic [2:0] OCM_PWM2         = 3'd7;

   // Capture edge selection, {CC1NP, CC1P}.
   localparam logic [1:0] EDGE_FALLING = 2'b01;
   localparam logic [1:0] EDGE_BOTH    = 2'b11;

   typedef struct packed {
      logic [1:0]        command;
      logic [3:0]        reg_addr;
      logic [DATA_W-1:0] write_data;
      logic              pin_level;
   } req_type;

   typedef struct packed {
      logic [DATA_W-1:0] read_data;
      logic              irq;
      logic              channel_out;
   } rsp_type;

endpackage

@@ rtl/core/general_purpose_timer_channel_core.sv @@
// General-purpose timer with one capture/compare channel.
// Every request on the req_ channel is a tick (the timer, if enabled, advances
// by one prescaler step and the channel pin is sampled), a register read, a
// register write or, for the unused command code, no operation. Each request
// yields exactly one response on the rsp_ channel with the read data (zero
// unless a read), the interrupt line and the channel output level, all taken
// after the request has taken effect. A request waits in the input register
// until the response register can take its result, which it then registers.
// Throughput: one request per cycle while the receiver does not stall; the
// whole timer update for one request is a single pass of logic between the
// input register and the response register, so back-to-back requests run
// without gaps.
// When the receiver stalls, the response register holds its contents; the
// input register still takes one more request, and req_stall rises only when
// that request cannot move on.
// Reset (synchronous, active high) empties both registers, clears all timer
// registers and sets the reload value to all ones of the counter width.
`timescale 1ns / 1ps

`include "general_purpose_timer_channel_core_assert.svh"

module general_purpose_timer_channel_core #(
   parameter int COUNTER_WIDTH  = gptc_pkg::COUNTER_WIDTH_DEFAULT,
   parameter int PRESCALE_WIDTH = gptc_pkg::PRESCALE_WIDTH_DEFAULT
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  gptc_pkg::req_type req_payload,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output gptc_pkg::rsp_type rsp_payload
);

   logic              in_valid;
   gptc_pkg::req_type in_data;
   gptc_pkg::rsp_type result;
   logic              out_ready;
   logic              advance;

   // A held request executes whenever the response register can take it.
   assign advance = in_valid & out_ready;

   gptc_in_reg u_in_reg (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_payload (req_payload),
      .advance     (advance),
      .in_valid    (in_valid),
      .in_data     (in_data)
   );

   // Timer state and the single-pass update for one request.
   gptc_engine #(
      .CounterWidth  (COUNTER_WIDTH),
      .PrescaleWidth (PRESCALE_WIDTH)
   ) u_engine (
      .clock   (clock),
      .reset   (reset),
      .advance (advance),
      .item    (in_data),
      .result  (result)
   );

   gptc_out_reg u_out_reg (
      .clock       (clock),
      .reset       (reset),
      .advance     (advance),
      .result      (result),
      .out_ready   (out_ready),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload)
   );

   // Back pressure toward the requester only when a request is held.
   `GPTC_ASSERT_NOW(a_stall_needs_held_request, clock, reset, req_stall, in_valid, "stall without a held request")
   // An executed request always leaves a response behind.
   `GPTC_ASSERT_NEXT(a_advance_gives_response, clock, reset, advance, rsp_valid, "executed request lost its response")
   // A delivered response with nothing behind it leaves the output empty.
   `GPTC_ASSERT_NEXT(a_drain_empties_output, clock, reset, rsp_valid && !rsp_stall && !in_valid, !rsp_valid, "response repeated after delivery")

endmodule

@@ rtl/core/gptc_in_reg.sv @@
`timescale 1ns / 1ps

module gptc_in_reg (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  gptc_pkg::req_type req_payload,
   input  logic             advance,
   output logic             in_valid,
   output gptc_pkg::req_type in_data
);

   logic              valid_ff;
   logic              valid_in;
   gptc_pkg::req_type data_ff;
   logic              accept;

   // The held request may leave in the same cycle a new one arrives.
   assign req_stall = valid_ff & ~advance;
   assign accept    = req_valid & ~req_stall;

   always_comb begin
      if (accept) begin
         valid_in = 1'b1;
      end else if (advance) begin
         valid_in = 1'b0;
      end else begin
         valid_in = valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         data_ff <= req_payload;
      end
   end

   assign in_valid = valid_ff;
   assign in_data  = data_ff;

endmodule

@@ rtl/core/gptc_engine.sv @@
`timescale 1ns / 1ps

module gptc_engine #(
   parameter int CounterWidth  = gptc_pkg::COUNTER_WIDTH_DEFAULT,
   parameter int PrescaleWidth = gptc_pkg::PRESCALE_WIDTH_DEFAULT
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              advance,
   input  gptc_pkg::req_type item,
   output gptc_pkg::rsp_type result
);

   localparam int DW = gptc_pkg::DATA_W;

   logic [1:0]               ctrl_ff, ctrl_in;
   logic [1:0]               irq_en_ff, irq_en_in;
   logic [1:0]               status_ff, status_in;
   logic [7:0]               mode_ff, mode_in;
   logic [3:0]               chan_en_ff, chan_en_in;
   logic [CounterWidth-1:0]  count_ff, count_in;
   logic [PrescaleWidth-1:0] psc_count_ff, psc_count_in;
   logic [PrescaleWidth-1:0] psc_pre_ff, psc_pre_in;
   logic [PrescaleWidth-1:0] psc_act_ff, psc_act_in;
   logic [CounterWidth-1:0]  arr_pre_ff, arr_pre_in;
   logic [CounterWidth-1:0]  arr_act_ff, arr_act_in;
   logic [CounterWidth-1:0]  ccr_pre_ff, ccr_pre_in;
   logic [CounterWidth-1:0]  ccr_act_ff, ccr_act_in;
   logic                     last_pin_ff, last_pin_in;

   logic [DW-1:0]            rd_data;
   logic                     oc_ref;

   always_comb begin
      logic                    capture_mode;
      logic                    rise;
      logic                    fall;
      logic                    hit;
      logic [CounterWidth-1:0] wdata;

      ctrl_in      = ctrl_ff;
      irq_en_in    = irq_en_ff;
      status_in    = status_ff;
      mode_in      = mode_ff;
      chan_en_in   = chan_en_ff;
      count_in     = count_ff;
      psc_count_in = psc_count_ff;
      psc_pre_in   = psc_pre_ff;
      psc_act_in   = psc_act_ff;
      arr_pre_in   = arr_pre_ff;
      arr_act_in   = arr_act_ff;
      ccr_pre_in   = ccr_pre_ff;
      ccr_act_in   = ccr_act_ff;
      last_pin_in  = last_pin_ff;
      rd_data      = '0;

      capture_mode = (mode_ff[1:0] != 2'b00);
      rise         = item.pin_level & ~last_pin_ff;
      fall         = ~item.pin_level & last_pin_ff;
      wdata        = item.write_data[CounterWidth-1:0];
      hit          = 1'b0;

      case (item.command)
         gptc_pkg::CMD_TICK: begin
            last_pin_in = item.pin_level;
            if (capture_mode && chan_en_ff[0]) begin
               case ({chan_en_ff[3], chan_en_ff[1]})
                  gptc_pkg::EDGE_FALLING: hit = fall;
                  gptc_pkg::EDGE_BOTH:    hit = rise | fall;
                  default:                hit = rise;
               endcase
               // The capture takes the count before this tick advances it.
               if (hit) begin
                  ccr_pre_in   = count_ff;
                  ccr_act_in   = count_ff;
                  status_in[1] = 1'b1;
               end
            end
            if (ctrl_ff[0]) begin
               if (psc_count_ff >= psc_act_ff) begin
                  psc_count_in = '0;
                  // A zero reload value holds the counter still.
                  if (arr_act_ff != '0) begin
                     if (count_ff == arr_act_ff) begin
                        count_in   = '0;
                        psc_act_in = psc_pre_ff;
                        arr_act_in = arr_pre_ff;
                        if (!capture_mode) begin
                           ccr_act_in = ccr_pre_ff;
                        end
                        status_in[0] = 1'b1;
                     end else begin
                        count_in = count_ff + 1'b1;
                     end
                     if (!capture_mode && (count_in == ccr_act_in)) begin
                        status_in[1] = 1'b1;
                     end
                  end
               end else begin
                  psc_count_in = psc_count_ff + 1'b1;
               end
            end
         end

         gptc_pkg::CMD_READ: begin
            case (item.reg_addr)
               gptc_pkg::REG_CTRL:      rd_data = DW'(ctrl_ff);
               gptc_pkg::REG_IRQ_EN:    rd_data = DW'(irq_en_ff);
               gptc_pkg::REG_STATUS:    rd_data = DW'(status_ff);
               gptc_pkg::REG_CHAN_MODE: rd_data = DW'(mode_ff);
               gptc_pkg::REG_CHAN_EN:   rd_data = DW'(chan_en_ff);
               gptc_pkg::REG_COUNT:     rd_data = DW'(count_ff);
               gptc_pkg::REG_PRESCALE:  rd_data = DW'(psc_pre_ff);
               gptc_pkg::REG_RELOAD:    rd_data = DW'(arr_pre_ff);
               gptc_pkg::REG_COMPARE: begin
                  // Reading the captured value acknowledges the capture flag.
                  if (capture_mode) begin
                     status_in[1] = 1'b0;
                     rd_data      = DW'(ccr_act_ff);
                  end else begin
                     rd_data = DW'(ccr_pre_ff);
                  end
               end
               default: rd_data = '0;
            endcase
         end

         gptc_pkg::CMD_WRITE: begin
            case (item.reg_addr)
               gptc_pkg::REG_CTRL:   ctrl_in   = item.write_data[1:0];
               gptc_pkg::REG_IRQ_EN: irq_en_in = item.write_data[1:0];
               gptc_pkg::REG_STATUS: status_in = status_ff & item.write_data[1:0];
               gptc_pkg::REG_EVENT: begin
                  if (item.write_data[0]) begin
                     count_in     = '0;
                     psc_count_in = '0;
                     psc_act_in   = psc_pre_ff;
                     arr_act_in   = arr_pre_ff;
                     if (!capture_mode) begin
                        ccr_act_in = ccr_pre_ff;
                     end
                     status_in[0] = 1'b1;
                  end
                  if (item.write_data[1]) begin
                     // A forced capture sees the count after a forced update.
                     if (capture_mode) begin
                        ccr_pre_in = count_in;
                        ccr_act_in = count_in;
                     end
                     status_in[1] = 1'b1;
                  end
               end
               gptc_pkg::REG_CHAN_MODE: mode_in    = item.write_data[7:0];
               gptc_pkg::REG_CHAN_EN:   chan_en_in = item.write_data[3:0];
               gptc_pkg::REG_COUNT:     count_in   = wdata;
               gptc_pkg::REG_PRESCALE:  psc_pre_in = item.write_data[PrescaleWidth-1:0];
               gptc_pkg::REG_RELOAD: begin
                  arr_pre_in = wdata;
                  if (!ctrl_ff[1]) begin
                     arr_act_in = wdata;
                  end
               end
               gptc_pkg::REG_COMPARE: begin
                  if (!capture_mode) begin
                     ccr_pre_in = wdata;
                     if (!mode_ff[3]) begin
                        ccr_act_in = wdata;
                     end
                  end
               end
               default: begin
               end
            endcase
         end

         default: begin
         end
      endcase
   end

   // Output compare reference, taken from the state after this request.
   always_comb begin
      case (mode_in[6:4])
         gptc_pkg::OCM_FORCE_ACTIVE: oc_ref = 1'b1;
         gptc_pkg::OCM_PWM1:         oc_ref = (count_in < ccr_act_in);
         gptc_pkg::OCM_PWM2:         oc_ref = (count_in >= ccr_act_in);
         default:                    oc_ref = 1'b0;
      endcase
   end

   always_comb begin
      result.read_data   = rd_data;
      result.irq         = |(status_in & irq_en_in);
      result.channel_out = chan_en_in[0] & (mode_in[1:0] == 2'b00) & (oc_ref ^ chan_en_in[1]);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ctrl_ff      <= '0;
         irq_en_ff    <= '0;
         status_ff    <= '0;
         mode_ff      <= '0;
         chan_en_ff   <= '0;
         count_ff     <= '0;
         psc_count_ff <= '0;
         psc_pre_ff   <= '0;
         psc_act_ff   <= '0;
         arr_pre_ff   <= '1;
         arr_act_ff   <= '1;
         ccr_pre_ff   <= '0;
         ccr_act_ff   <= '0;
         last_pin_ff  <= 1'b0;
      end else if (advance) begin
         ctrl_ff      <= ctrl_in;
         irq_en_ff    <= irq_en_in;
         status_ff    <= status_in;
         mode_ff      <= mode_in;
         chan_en_ff   <= chan_en_in;
         count_ff     <= count_in;
         psc_count_ff <= psc_count_in;
         psc_pre_ff   <= psc_pre_in;
         psc_act_ff   <= psc_act_in;
         arr_pre_ff   <= arr_pre_in;
         arr_act_ff   <= arr_act_in;
         ccr_pre_ff   <= ccr_pre_in;
         ccr_act_ff   <= ccr_act_in;
         last_pin_ff  <= last_pin_in;
      end
   end

endmodule

@@ rtl/core/gptc_out_reg.sv @@
`timescale 1ns / 1ps

module gptc_out_reg (
   input  logic              clock,
   input  logic              reset,
   input  logic              advance,
   input  gptc_pkg::rsp_type result,
   output logic              out_ready,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output gptc_pkg::rsp_type rsp_payload
);

   logic              valid_ff;
   logic              valid_in;
   gptc_pkg::rsp_type data_ff;

   // The register can take a new result when empty or when its result leaves.
   assign out_ready = ~valid_ff | ~rsp_stall;

   always_comb begin
      if (advance) begin
         valid_in = 1'b1;
      end else if (~rsp_stall) begin
         valid_in = 1'b0;
      end else begin
         valid_in = valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         data_ff <= result;
      end
   end

   assign rsp_valid   = valid_ff;
   assign rsp_payload = data_ff;

endmodule

@@ test/testbench.sv @@
`timescale 1ns / 1ps

module testbench;

   // The package names the three real commands; the fourth encoding must be a no-op.
   localparam logic [1:0] CMD_UNUSED = 2'd3;

   // Bit positions inside the timer registers.
   localparam int CTRL_CEN    = 0;
   localparam int CTRL_ARPE   = 1;
   localparam int STAT_UIF    = 0;
   localparam int STAT_CC1IF  = 1;
   localparam int EV_UG       = 0;
   localparam int EV_CC1G     = 1;
   localparam int CHEN_CC1E   = 0;
   localparam int CHEN_CC1P   = 1;
   localparam int CHEN_CC1NP  = 3;
   localparam int MODE_OC1PE  = 3;

   // Timer model plus the queue of responses it has predicted.
   // Every accepted request produces exactly one response, so the queue
   // order is the request order.
   class timer_scoreboard;
      bit [1:0]  ctrl, irq_en, status;
      bit [7:0]  chan_mode;
      bit [3:0]  chan_en;
      bit [31:0] count, reload_pre, reload_act, compare_pre, compare_act;
      bit [15:0] psc_count, psc_pre, psc_act;
      bit        pin_prev;
      gptc_pkg::rsp_type pending[$];
      int        mismatches;

      function new();
         ctrl = '0; irq_en = '0; status = '0; chan_mode = '0; chan_en = '0;
         count = '0; psc_count = '0; psc_pre = '0; psc_act = '0;
         reload_pre = '1; reload_act = '1;
         compare_pre = '0; compare_act = '0;
         pin_prev = 1'b0;
         mismatches = 0;
      endfunction

      function bit capture_mode();
         return chan_mode[1:0] != 2'b00;
      endfunction

      // Update event: clear both counters, load the shadow registers, flag it.
      function void update_event();
         count = '0;
         psc_count = '0;
         psc_act = psc_pre;
         reload_act = reload_pre;
         if (!capture_mode())
            compare_act = compare_pre;
         status[STAT_UIF] = 1'b1;
      endfunction

      function void capture_count();
         compare_pre = count;
         compare_act = count;
         status[STAT_CC1IF] = 1'b1;
      endfunction

      // Apply one request to the model and queue the response it must give.
      function void note_request(gptc_pkg::req_type r);
         gptc_pkg::rsp_type want;
         bit         rise, fall, hit, level;
         logic [1:0] edge_sel;
         logic [31:0] d;
         want = '0;
         d = r.write_data;
         case (r.command)
            gptc_pkg::CMD_TICK: begin
               // Edges are watched on every tick, whether or not the counter runs.
               rise = r.pin_level && !pin_prev;
               fall = !r.pin_level && pin_prev;
               pin_prev = r.pin_level;
               if (capture_mode() && chan_en[CHEN_CC1E]) begin
                  edge_sel = {chan_en[CHEN_CC1NP], chan_en[CHEN_CC1P]};
                  if (edge_sel == gptc_pkg::EDGE_FALLING)
                     hit = fall;
                  else if (edge_sel == gptc_pkg::EDGE_BOTH)
                     hit = rise || fall;
                  else
                     hit = rise;
                  if (hit)
                     capture_count();
               end
               if (ctrl[CTRL_CEN]) begin
                  if (psc_count >= psc_act) begin
                     psc_count = '0;
                     // A zero reload value freezes the counter.
                     if (reload_act != '0) begin
                        if (count == reload_act)
                           update_event();
                        else
                           count = count + 1;
                        if (!capture_mode() && count == compare_act)
                           status[STAT_CC1IF] = 1'b1;
                     end
                  end else begin
                     psc_count = psc_count + 1;
                  end
               end
            end
            gptc_pkg::CMD_READ: begin
               case (r.reg_addr)
                  gptc_pkg::REG_CTRL:      want.read_data = ctrl;
                  gptc_pkg::REG_IRQ_EN:    want.read_data = irq_en;
                  gptc_pkg::REG_STATUS:    want.read_data = status;
                  gptc_pkg::REG_CHAN_MODE: want.read_data = chan_mode;
                  gptc_pkg::REG_CHAN_EN:   want.read_data = chan_en;
                  gptc_pkg::REG_COUNT:     want.read_data = count;
                  gptc_pkg::REG_PRESCALE:  want.read_data = psc_pre;
                  gptc_pkg::REG_RELOAD:    want.read_data = reload_pre;
                  gptc_pkg::REG_COMPARE: begin
                     // In capture mode, reading the captured value acknowledges it.
                     if (capture_mode()) begin
                        status[STAT_CC1IF] = 1'b0;
                        want.read_data = compare_act;
                     end else begin
                        want.read_data = compare_pre;
                     end
                  end
                  default:       want.read_data = '0;
               endcase
            end
            gptc_pkg::CMD_WRITE: begin
               case (r.reg_addr)
                  gptc_pkg::REG_CTRL:      ctrl = d[1:0];
                  gptc_pkg::REG_IRQ_EN:    irq_en = d[1:0];
                  gptc_pkg::REG_STATUS:    status = status & d[1:0];
                  gptc_pkg::REG_EVENT: begin
                     if (d[EV_UG])
                        update_event();
                     if (d[EV_CC1G]) begin
                        if (capture_mode())
                           capture_count();
                        else
                           status[STAT_CC1IF] = 1'b1;
                     end
                  end
                  gptc_pkg::REG_CHAN_MODE: chan_mode = d[7:0];
                  gptc_pkg::REG_CHAN_EN:   chan_en = d[3:0];
                  gptc_pkg::REG_COUNT:     count = d;
                  gptc_pkg::REG_PRESCALE:  psc_pre = d[15:0];
                  gptc_pkg::REG_RELOAD: begin
                     reload_pre = d;
                     if (!ctrl[CTRL_ARPE])
                        reload_act = d;
                  end
                  gptc_pkg::REG_COMPARE: begin
                     if (!capture_mode()) begin
                        compare_pre = d;
                        if (!chan_mode[MODE_OC1PE])
                           compare_act = d;
                     end
                  end
                  default: ;
               endcase
            end
            default: ;
         endcase
         if (chan_en[CHEN_CC1E] && !capture_mode()) begin
            case (chan_mode[6:4])
               gptc_pkg::OCM_FORCE_ACTIVE: level = 1'b1;
               gptc_pkg::OCM_PWM1:         level = count < compare_act;
               gptc_pkg::OCM_PWM2:         level = count >= compare_act;
               default:                    level = 1'b0;
            endcase
            want.channel_out = level ^ chan_en[CHEN_CC1P];
         end
         want.irq = |(status & irq_en);
         pending.push_back(want);
      endfunction

      task report(string field, logic [31:0] got, logic [31:0] want);
         $display("%0t mismatch on %s: got %h, expected %h", $realtime, field, got, want);
         mismatches++;
      endtask

      task check_response(gptc_pkg::rsp_type got);
         gptc_pkg::rsp_type want;
         if (pending.size() == 0) begin
            report("unrequested response", got.read_data, '0);
         end else begin
            want = pending.pop_front();
            if (got.read_data !== want.read_data)
               report("read_data", got.read_data, want.read_data);
            if (got.irq !== want.irq)
               report("irq", got.irq, want.irq);
            if (got.channel_out !== want.channel_out)
               report("channel_out", got.channel_out, want.channel_out);
         end
      endtask
   endclass

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              req_valid = 1'b0;
   logic              req_stall;
   gptc_pkg::req_type req_payload = '0;
   logic              rsp_valid;
   logic              rsp_stall = 1'b0;
   gptc_pkg::rsp_type rsp_payload;

   timer_scoreboard sb = new();

   // Percent chances of an idle sender cycle and of a stalled receiver cycle;
   // the main sequence changes them from phase to phase.
   int sender_idle_pct = 0;
   int receiver_stall_pct = 0;
   // When set, the receiver holds stall high for this many cycles in a row.
   int holdoff_cycles = 0;

   general_purpose_timer_channel_core DUT (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload)
   );

   always #5 clock = ~clock;

   function automatic gptc_pkg::req_type make_req(logic [1:0] cmd, logic [3:0] addr,
                                                  logic [31:0] data, logic pin);
      gptc_pkg::req_type r;
      r.command = cmd;
      r.reg_addr = addr;
      r.write_data = data;
      r.pin_level = pin;
      return r;
   endfunction

   // Random request, shaped so that the counter actually wraps: mostly ticks,
   // small reload, prescale and compare values, with the occasional full-width
   // value and stray address or command mixed in.
   function automatic gptc_pkg::req_type random_request();
      gptc_pkg::req_type r;
      int                pick;
      r = make_req(gptc_pkg::CMD_TICK, 4'($urandom_range(15)), $urandom(),
                   1'($urandom_range(1)));
      pick = $urandom_range(99);
      if (pick < 55) begin
         r.command = gptc_pkg::CMD_TICK;
      end else if (pick < 70) begin
         r.command = gptc_pkg::CMD_READ;
         if ($urandom_range(9) != 0)
            r.reg_addr = 4'($urandom_range(9));
      end else if (pick < 97) begin
         r.command = gptc_pkg::CMD_WRITE;
         if ($urandom_range(9) != 0)
            r.reg_addr = 4'($urandom_range(9));
         case (r.reg_addr)
            gptc_pkg::REG_CTRL:      r.write_data[CTRL_CEN] = $urandom_range(99) < 85;
            gptc_pkg::REG_CHAN_MODE: if ($urandom_range(1) == 0) r.write_data[1:0] = 2'b00;
            gptc_pkg::REG_RELOAD: begin
               pick = $urandom_range(19);
               if (pick == 0)
                  r.write_data = '0;
               else if (pick > 1)
                  r.write_data = $urandom_range(12, 1);
            end
            gptc_pkg::REG_PRESCALE:  if ($urandom_range(9) != 0) r.write_data = $urandom_range(2);
            gptc_pkg::REG_COMPARE:   if ($urandom_range(9) != 0) r.write_data = $urandom_range(13);
            gptc_pkg::REG_COUNT: begin
               pick = $urandom_range(9);
               // Near full scale the counter has to wrap without an update.
               if (pick == 0)
                  r.write_data = 32'hFFFF_FFFD + $urandom_range(2);
               else if (pick > 1)
                  r.write_data = $urandom_range(12);
            end
            default: ;
         endcase
      end else begin
         r.command = CMD_UNUSED;
      end
      return r;
   endfunction

   // Offer one request, possibly after some idle cycles, and return once it
   // has been accepted. Valid stays high afterwards; the next call lowers it
   // only when it idles, and the end of the sequence at a later falling edge.
   task automatic send_request(gptc_pkg::req_type r);
      while ($urandom_range(99) < sender_idle_pct)
         @(negedge clock) req_valid <= 1'b0;
      @(negedge clock);
      req_valid <= 1'b1;
      req_payload <= r;
      do
         @(posedge clock);
      while (req_stall);
      sb.note_request(r);
   endtask

   // Receiver: random stalls, or one long hold-off when asked for, so that the
   // block fills up and pushes back on the request side.
   initial begin
      int held;
      forever begin
         if (holdoff_cycles > 0) begin
            held = holdoff_cycles;
            holdoff_cycles = 0;
            repeat (held) @(negedge clock) rsp_stall <= 1'b1;
         end else begin
            @(negedge clock) rsp_stall <= $urandom_range(99) < receiver_stall_pct;
         end
      end
   end

   // Every response taken by the receiver is checked against the model.
   always @(posedge clock)
      if (!reset && rsp_valid && !rsp_stall)
         sb.check_response(rsp_payload);

   initial begin
      gptc_pkg::req_type directed[$];
      int                phase;

      // Directed opening: reset values, unknown addresses and command, a PWM
      // setup with update and forced compare events, full-scale wrap above the
      // reload value, captures on both edges, and a zero reload value.
      directed.push_back(make_req(gptc_pkg::CMD_READ, gptc_pkg::REG_RELOAD, '0, 1'b0));
      directed.push_back(make_req(gptc_pkg::CMD_READ, 4'd15, '0, 1'b1));
      directed.push_back(make_req(CMD_UNUSED, gptc_pkg::REG_CTRL, '1, 1'b1));
      directed.push_back(make_req(gptc_pkg::CMD_WRITE, 4'd12, '1, 1'b0));
      directed.push_back(make_req(gptc_pkg::CMD_WRITE, gptc_pkg::REG_CHAN_MODE,
                                  {24'd0, 1'b0, gptc_pkg::OCM_PWM1, 4'b1000}, 1'b0));
      directed.push_back(make_req(gptc_pkg::CMD_WRITE, gptc_pkg::REG_CHAN_EN, 32'd1, 1'b0));
      directed.push_back(make_req(gptc_pkg::CMD_WRITE, gptc_pkg::REG_COMPARE, 32'd3, 1'b0));
      directed.push_back(make_req(gptc_pkg::CMD_WRITE, gptc_pkg::REG_RELOAD, 32'd5, 1'b0));
      directed.push_back(make_req(gptc_pkg::CMD_WRITE, gptc_pkg::REG_PRESCALE, 32'd1, 1'b0));
      directed.push_back(make_req(gptc_pkg::CMD_WRITE, gptc_pkg::REG_IRQ_EN, 32'd3, 1'b0));
      directed.push_back(make_req(gptc_pkg::CMD_WRITE, gptc_pkg::REG_EVENT, 32'd3, 1'b0));
      directed.push_back(make_req(gptc_pkg::CMD_WRITE, gptc_pkg::REG_CTRL, 32'd3, 1'b0));
      directed.push_back(make_req(gptc_pkg::CMD_TICK, gptc_pkg::REG_CTRL, '0, 1'b1));
      directed.push_back(make_req(gptc_pkg::CMD_TICK, gptc_pkg::REG_CTRL, '0, 1'b0));
      directed.push_back(make_req(gptc_pkg::CMD_TICK, gptc_pkg::REG_CTRL, '0, 1'b1));
      directed.push_back(make_req(gptc_pkg::CMD_WRITE, gptc_pkg::REG_COUNT, 32'hFFFF_FFFF,
                                  1'b0));
      directed.push_back(make_req(gptc_pkg::CMD_TICK, gptc_pkg::REG_CTRL, '0, 1'b0));
      directed.push_back(make_req(gptc_pkg::CMD_TICK, gptc_pkg::REG_CTRL, '0, 1'b0));
      directed.push_back(make_req(gptc_pkg::CMD_WRITE, gptc_pkg::REG_STATUS, '0, 1'b0));
      directed.push_back(make_req(gptc_pkg::CMD_WRITE, gptc_pkg::REG_CHAN_MODE, 32'd1, 1'b0));
      directed.push_back(make_req(gptc_pkg::CMD_WRITE, gptc_pkg::REG_CHAN_EN, 32'hB, 1'b0));
      directed.push_back(make_req(gptc_pkg::CMD_TICK, gptc_pkg::REG_CTRL, '0, 1'b1));
      directed.push_back(make_req(gptc_pkg::CMD_TICK, gptc_pkg::REG_CTRL, '0, 1'b0));
      directed.push_back(make_req(gptc_pkg::CMD_READ, gptc_pkg::REG_COMPARE, '0, 1'b0));
      directed.push_back(make_req(gptc_pkg::CMD_WRITE, gptc_pkg::REG_RELOAD, '0, 1'b0));
      directed.push_back(make_req(gptc_pkg::CMD_WRITE, gptc_pkg::REG_EVENT, 32'd1, 1'b0));

      repeat (2) @(posedge clock);
      @(negedge clock) reset <= 1'b0;

      foreach (directed[i])
         send_request(directed[i]);

      // Random phases: no idling (with one long receiver hold-off), an idle
      // sender, a stalling receiver, then both at a lower rate.
      for (phase = 0; phase < 4; phase++) begin
         sender_idle_pct    = (phase == 1) ? 45 : (phase == 3) ? 15 : 0;
         receiver_stall_pct = (phase == 2) ? 45 : (phase == 3) ? 15 : 0;
         if (phase == 0)
            holdoff_cycles = 60;
         repeat (110)
            send_request(random_request());
      end
      @(negedge clock) req_valid <= 1'b0;

      // Drain: every predicted response must arrive, then a few quiet cycles
      // to catch anything extra.
      while (sb.pending.size() != 0)
         @(posedge clock);
      repeat (10) @(posedge clock);

      if (sb.mismatches == 0)
         $display("PASS general_purpose_timer_channel_core");
      else
         $display("FAIL general_purpose_timer_channel_core");
      $finish;
   end

   // Watchdog against a hung handshake.
   initial begin
      #2_000_000;
      $display("FAIL general_purpose_timer_channel_core");
      $finish;
   end

endmodule
